// ----- hw/rtl/sts_pkg.sv -----
`default_nettype none
package sts_pkg;

    localparam int TABLE_DEPTH = 1024;
    localparam int VALUE_W     = 32;
    localparam int ADDR_W      = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = ADDR_W + 1;
    localparam int IN_DATA_W   = ((ADDR_W + VALUE_W + 7) / 8) * 8;
    localparam int OUT_DATA_W  = ((ADDR_W + 7) / 8) * 8;

    localparam logic OP_WRITE  = 1'b0;
    localparam logic OP_SEARCH = 1'b1;

    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(TABLE_DEPTH);

    typedef struct packed {
        logic write_en;
        logic start;
        logic probe;
        logic compare;
        logic load_out;
    } sts_cmd_t;

    typedef struct packed {
        logic range_open;
        logic hit;
    } sts_status_t;

endpackage
`default_nettype wire

// ----- hw/rtl/sorted_table_binary_search.sv -----
// Write word: accepted while idle, no result, next word taken the cycle after.
// Search word: each probe is a registered table read, then a compare; a miss
// ends with one final range check, and the result load waits until the output
// is free.
// Reset (aresetn low, synchronous) clears the control state and entries_in_use;
// table contents stay undefined until written.
`default_nettype none
module sorted_table_binary_search
    import sts_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CNT_W-1:0]      cfg_data,    // entries_in_use
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [IN_DATA_W-1:0]  s_tdata,     // slot, value, zero pad
    input  wire logic                  s_tuser,     // operation
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [OUT_DATA_W-1:0]      m_tdata,     // position, zero pad
    output logic                       m_tuser      // found
);

    sts_cmd_t          cmd;
    sts_status_t       status;
    logic              out_found;
    logic [ADDR_W-1:0] out_position;

    assign cfg_ready = 1'b1;

    sts_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_op     (s_tuser),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    sts_datapath u_datapath (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_we       (cfg_valid),
        .cfg_count    (cfg_data),
        .in_slot      (s_tdata[ADDR_W-1:0]),
        .in_value     (s_tdata[ADDR_W +: VALUE_W]),
        .cmd          (cmd),
        .status       (status),
        .out_found    (out_found),
        .out_position (out_position)
    );

    assign m_tdata = OUT_DATA_W'(out_position);
    assign m_tuser = out_found;

    // a miss always reports slot zero
    a_miss_pos_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |-> m_tdata[ADDR_W-1:0] == '0)
        else $error("miss with nonzero position");

    // a search holds off further input words
    a_search_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tuser == OP_SEARCH |=> !s_tready)
        else $error("input taken during search");

    // new results only come out of a search in progress
    a_result_from_search: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(!s_tready))
        else $error("result without search");

    // while a search is in progress, control issues no table write and no start
    a_no_write_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> !cmd.write_en && !cmd.start)
        else $error("table command while busy");

endmodule
`default_nettype wire

// ----- hw/rtl/sts_ctrl.sv -----
`default_nettype none
module sts_ctrl
    import sts_pkg::*;
(
    input  wire logic  aclk,
    input  wire logic  aresetn,
    input  wire logic  s_tvalid,
    input  wire logic  s_op,
    output logic       s_tready,
    output logic       m_tvalid,
    input  wire logic  m_tready,
    input  sts_status_t status,
    output sts_cmd_t   cmd
);

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_PROBE = 4'b0010,
        ST_CMP   = 4'b0100,
        ST_DONE  = 4'b1000
    } state_t;

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;
    logic   out_free;

    assign out_free = !m_valid_reg || m_tready;
    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_valid_reg;

    always_comb begin
        cmd          = '0;
        state_next   = state_reg;
        m_valid_next = m_valid_reg && !m_tready;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    if (s_op == OP_SEARCH) begin
                        cmd.start  = 1'b1;
                        state_next = ST_PROBE;
                    end else begin
                        cmd.write_en = 1'b1;
                    end
                end
            end
            ST_PROBE: begin
                if (status.range_open) begin
                    cmd.probe  = 1'b1;
                    state_next = ST_CMP;
                end else begin
                    state_next = ST_DONE;
                end
            end
            ST_CMP: begin
                cmd.compare = 1'b1;
                state_next  = status.hit ? ST_DONE : ST_PROBE;
            end
            ST_DONE: begin
                if (out_free) begin
                    cmd.load_out = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule
`default_nettype wire

// ----- hw/rtl/sts_datapath.sv -----
`default_nettype none
module sts_datapath
    import sts_pkg::*;
(
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               cfg_we,
    input  wire logic [CNT_W-1:0]   cfg_count,
    input  wire logic [ADDR_W-1:0]  in_slot,
    input  wire logic [VALUE_W-1:0] in_value,
    input  sts_cmd_t                cmd,
    output sts_status_t             status,
    output logic                    out_found,
    output logic [ADDR_W-1:0]       out_position
);

    logic [VALUE_W-1:0] table_mem [TABLE_DEPTH];

    logic [CNT_W-1:0]   entries_reg;
    logic [CNT_W-1:0]   lo_reg, lo_next;
    logic [CNT_W-1:0]   end_reg, end_next;
    logic [VALUE_W-1:0] key_reg;
    logic [ADDR_W-1:0]  mid_reg;
    logic [VALUE_W-1:0] rd_data_reg;
    logic               res_found_reg, res_found_next;
    logic [ADDR_W-1:0]  res_pos_reg, res_pos_next;
    logic               out_found_reg;
    logic [ADDR_W-1:0]  out_pos_reg;

    logic [CNT_W:0]     mid_sum;
    logic [ADDR_W-1:0]  mid;
    logic               probe_less;
    logic               probe_hit;

    // midpoint of [lo, end-1], floor
    assign mid_sum = {1'b0, lo_reg} + {1'b0, end_reg} - (CNT_W+1)'(1);
    assign mid     = mid_sum[ADDR_W:1];

    assign probe_less = $signed(rd_data_reg) < $signed(key_reg);
    assign probe_hit  = (rd_data_reg == key_reg);

    assign status.range_open = (lo_reg < end_reg);
    assign status.hit        = probe_hit;

    always_comb begin
        lo_next        = lo_reg;
        end_next       = end_reg;
        res_found_next = res_found_reg;
        res_pos_next   = res_pos_reg;
        priority if (cmd.start) begin
            lo_next        = '0;
            end_next       = (entries_reg > DEPTH_CNT) ? DEPTH_CNT : entries_reg;
            res_found_next = 1'b0;
            res_pos_next   = '0;
        end else if (cmd.compare) begin
            priority if (probe_hit) begin
                res_found_next = 1'b1;
                res_pos_next   = mid_reg;
            end else if (probe_less) begin
                lo_next = {1'b0, mid_reg} + CNT_W'(1);
            end else begin
                end_next = {1'b0, mid_reg};
            end
        end else begin
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            entries_reg <= '0;
        end else if (cfg_we) begin
            entries_reg <= cfg_count;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.write_en) begin
            table_mem[in_slot] <= in_value;
        end
    end

    always_ff @(posedge aclk) begin
        rd_data_reg <= table_mem[mid];
    end

    always_ff @(posedge aclk) begin
        lo_reg        <= lo_next;
        end_reg       <= end_next;
        res_found_reg <= res_found_next;
        res_pos_reg   <= res_pos_next;
        if (cmd.start) begin
            key_reg <= in_value;
        end
        if (cmd.probe) begin
            mid_reg <= mid;
        end
        if (cmd.load_out) begin
            out_found_reg <= res_found_reg;
            out_pos_reg   <= res_pos_reg;
        end
    end

    assign out_found    = out_found_reg;
    assign out_position = out_pos_reg;

endmodule
`default_nettype wire

// ----- test/testbench.sv -----
`timescale 1ns / 100ps

module testbench;
    import sts_pkg::*;

    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int SETTLE_CYCLES = 30;
    localparam int HOLD_CYCLES   = 400;
    localparam int WORD_TARGET   = 1200;

    localparam logic [VALUE_W-1:0] VALUE_MIN = {1'b1, {(VALUE_W-1){1'b0}}};
    localparam logic [VALUE_W-1:0] VALUE_MAX = {1'b0, {(VALUE_W-1){1'b1}}};

    typedef struct packed {
        logic              found;
        logic [ADDR_W-1:0] position;
    } lookup_t;

    class search_scoreboard;
        logic signed [VALUE_W-1:0] table_q [TABLE_DEPTH];
        logic [CNT_W-1:0]          entries_q;
        lookup_t                   pending_lookups [$];
        int                        errors;
        int                        hits;
        int                        misses;
        int                        writes_seen;
        int                        searches_seen;

        function new();
            entries_q     = '0;
            errors        = 0;
            hits          = 0;
            misses        = 0;
            writes_seen   = 0;
            searches_seen = 0;
        endfunction

        function void set_entries(logic [CNT_W-1:0] cnt);
            entries_q = cnt;
        endfunction

        // halving search over the first entries_q slots, count saturated at table depth
        function lookup_t binary_lookup(logic signed [VALUE_W-1:0] key);
            int      lo;
            int      hi;
            int      mid;
            lookup_t res;
            res = '0;
            lo  = 0;
            hi  = ((entries_q > TABLE_DEPTH) ? TABLE_DEPTH : int'(entries_q)) - 1;
            while (lo <= hi) begin
                mid = lo + (hi - lo) / 2;
                if (table_q[mid] < key) begin
                    lo = mid + 1;
                end else if (table_q[mid] > key) begin
                    hi = mid - 1;
                end else begin
                    res.found    = 1'b1;
                    res.position = ADDR_W'(mid);
                    return res;
                end
            end
            return res;
        endfunction

        function void note_word(logic op, logic [ADDR_W-1:0] slot,
                                logic signed [VALUE_W-1:0] value);
            if (op == OP_WRITE) begin
                table_q[slot] = value;
                writes_seen++;
            end else begin
                pending_lookups.push_back(binary_lookup(value));
                searches_seen++;
            end
        endfunction

        function void check_result(logic found, logic [ADDR_W-1:0] position);
            lookup_t want;
            if (pending_lookups.size() == 0) begin
                $error("result word with no search outstanding: found %0d position %0d",
                       found, position);
                errors++;
                return;
            end
            want = pending_lookups.pop_front();
            if (found !== want.found) begin
                $error("found: expected %0d, got %0d", want.found, found);
                errors++;
            end
            if (position !== want.position) begin
                $error("position: expected %0d, got %0d", want.position, position);
                errors++;
            end
            if (want.found) begin
                hits++;
            end else begin
                misses++;
            end
        endfunction
    endclass

    bit                    aclk;
    logic                  aresetn;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CNT_W-1:0]      cfg_data;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata;     // slot, value, zero pad
    logic                  s_tuser;     // operation
    logic                  m_tvalid;
    logic                  m_tready;
    logic [OUT_DATA_W-1:0] m_tdata;     // position, zero pad
    logic                  m_tuser;     // found

    search_scoreboard sb;
    int  cycle_count  = 0;
    int  words_sent   = 0;
    int  config_count = 0;
    bit  tx_calm      = 1'b0;
    bit  rx_calm      = 1'b0;
    bit  long_hold    = 1'b0;

    sorted_table_binary_search u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("sorted_table_binary_search verification failed");
            $finish;
        end
    end

    // monitors: everything is noted at the edge where the handshake happens
    always @(posedge aclk) begin
        if (aresetn && cfg_valid && cfg_ready) begin
            sb.set_entries(cfg_data);
        end
        if (aresetn && s_tvalid && s_tready) begin
            sb.note_word(s_tuser, s_tdata[ADDR_W-1:0], s_tdata[ADDR_W +: VALUE_W]);
        end
        if (aresetn && m_tvalid && m_tready) begin
            sb.check_result(m_tuser, m_tdata[ADDR_W-1:0]);
        end
    end

    // result side: random stalls, plus one long hold-off on request
    initial begin
        int stall;
        m_tready = 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            @(negedge aclk);
            if (long_hold) begin
                m_tready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
                long_hold = 1'b0;
            end
            stall = rx_calm ? 0 : $urandom_range(0, 13);
            if (stall > 0) begin
                m_tready = 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_tready = 1'b1;
            do @(posedge aclk); while (!m_tvalid);
        end
    end

    task automatic send_word(input logic op, input logic [ADDR_W-1:0] slot,
                             input logic [VALUE_W-1:0] value);
        int gap;
        gap = tx_calm ? 0 : $urandom_range(0, 13);
        if (gap > 0) begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tuser  = op;
        s_tdata  = IN_DATA_W'({value, slot});
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
        s_tvalid = 1'b0;
        words_sent++;
    endtask

    task automatic wait_idle();
        while (sb.pending_lookups.size() != 0) @(negedge aclk);
        // a write word may still be settling after the last result
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic set_entries(input int cnt);
        cfg_valid = 1'b1;
        cfg_data  = CNT_W'(cnt);
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid = 1'b0;
        config_count++;
    endtask

    // style 0: sorted full range, 1: sorted with many duplicates, 2: unsorted
    task automatic fill_table(input int n, input int style);
        int vals [$];
        for (int i = 0; i < n; i++) begin
            if (style == 1) begin
                vals.push_back($urandom_range(0, 7) - 3);
            end else begin
                vals.push_back($urandom());
            end
        end
        if (style != 2) begin
            vals.sort();
        end
        if (style == 0 && $urandom_range(0, 3) == 0) begin
            vals[0]   = VALUE_MIN;
            vals[n-1] = VALUE_MAX;
        end
        for (int i = 0; i < n; i++) begin
            send_word(OP_WRITE, ADDR_W'(i), VALUE_W'(vals[i]));
        end
    endtask

    function automatic logic [VALUE_W-1:0] pick_key(input int n);
        int                 sel;
        logic [VALUE_W-1:0] k;
        sel = $urandom_range(0, 9);
        k   = sb.table_q[$urandom_range(0, n - 1)];
        case (sel)
            6: k = k + 1'b1;
            7: k = k - 1'b1;
            8: k = $urandom();
            9: k = $urandom_range(0, 1) ? VALUE_MIN : VALUE_MAX;
            default: ;
        endcase
        return k;
    endfunction

    // searches over slots below n, with the odd rewrite that breaks the order
    task automatic search_burst(input int n, input int count);
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(0, 11) == 0) begin
                send_word(OP_WRITE, ADDR_W'($urandom_range(0, n - 1)), $urandom());
            end else begin
                send_word(OP_SEARCH, ADDR_W'($urandom()), pick_key(n));
            end
        end
    endtask

    initial begin
        int n;
        int phase;
        sb        = new();
        aresetn   = 1'b0;
        cfg_valid = 1'b0;
        cfg_data  = '0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = OP_WRITE;
        repeat (10) @(negedge aclk);
        aresetn = 1'b1;

        // empty table straight out of reset
        send_word(OP_SEARCH, '0, VALUE_MIN);
        send_word(OP_SEARCH, '1, VALUE_MAX);
        send_word(OP_SEARCH, '0, '0);

        // small table with both extremes and a duplicate pair
        send_word(OP_WRITE, 10'd0, VALUE_MIN);
        send_word(OP_WRITE, 10'd1, 32'hffff_ffff);
        send_word(OP_WRITE, 10'd2, 32'd0);
        send_word(OP_WRITE, 10'd3, 32'd1);
        send_word(OP_WRITE, 10'd4, 32'd5);
        send_word(OP_WRITE, 10'd5, 32'd5);
        send_word(OP_WRITE, 10'd6, VALUE_MAX);
        send_word(OP_WRITE, 10'd1023, 32'h5555_5555);
        wait_idle();
        set_entries(7);
        send_word(OP_SEARCH, '0, VALUE_MIN);
        send_word(OP_SEARCH, '1, VALUE_MAX);
        send_word(OP_SEARCH, '0, 32'hffff_ffff);
        send_word(OP_SEARCH, '0, 32'd0);
        send_word(OP_SEARCH, '0, 32'd1);
        send_word(OP_SEARCH, '0, 32'd5);
        send_word(OP_SEARCH, '0, 32'd3);
        send_word(OP_SEARCH, '0, VALUE_MIN + 1'b1);
        send_word(OP_SEARCH, '0, 32'hffff_fffe);
        wait_idle();
        set_entries(1);
        send_word(OP_SEARCH, '0, VALUE_MIN);
        send_word(OP_SEARCH, '0, 32'd0);
        wait_idle();
        set_entries(0);
        send_word(OP_SEARCH, '0, VALUE_MIN);

        phase = 0;
        while (words_sent < WORD_TARGET) begin
            tx_calm = ($urandom_range(0, 3) == 0);
            rx_calm = ($urandom_range(0, 3) == 0);
            if (phase == 0) begin
                // whole table, then counts above the depth
                fill_table(TABLE_DEPTH, 0);
                wait_idle();
                set_entries(TABLE_DEPTH);
                search_burst(TABLE_DEPTH, 80);
                wait_idle();
                set_entries((1 << CNT_W) - 1);
                search_burst(TABLE_DEPTH, 30);
                wait_idle();
                set_entries($urandom_range(TABLE_DEPTH + 1, (1 << CNT_W) - 2));
                search_burst(TABLE_DEPTH, 20);
            end else begin
                n = ($urandom_range(0, 3) == 0) ? $urandom_range(41, 200)
                                                : $urandom_range(1, 40);
                fill_table(n, $urandom_range(0, 2));
                wait_idle();
                set_entries(($urandom_range(0, 4) == 0) ? $urandom_range(0, n) : n);
                if (phase == 1) begin
                    rx_calm   = 1'b0;
                    tx_calm   = 1'b1;
                    long_hold = 1'b1;
                end
                search_burst(n, $urandom_range(20, 40));
            end
            wait_idle();
            phase++;
        end

        s_tvalid = 1'b0;
        wait_idle();
        $display("Sent %0d table writes and %0d searches (%0d hits, %0d misses), %0d count writes",
                 sb.writes_seen, sb.searches_seen, sb.hits, sb.misses, config_count);
        $display("Tables from empty to all %0d slots: sorted, duplicated, unsorted, oversized counts",
                 TABLE_DEPTH);
        if (sb.errors == 0) begin
            $display("sorted_table_binary_search verification clean");
        end else begin
            $display("sorted_table_binary_search verification failed");
        end
        $finish;
    end

endmodule
